// ===== design/command_retransmit_slot_table_macros.svh =====
// assertion macros for the command retransmit slot table
// used by the top level only; no other dependencies
`ifndef COMMAND_RETRANSMIT_SLOT_TABLE_MACROS_SVH
`define COMMAND_RETRANSMIT_SLOT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CRST_ASSERT_NOW(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("crst check failed");
// next-cycle implication
`define CRST_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("crst check failed");
`else
`define CRST_ASSERT_NOW(lbl, clk, rst, a, c)
`define CRST_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

// ===== design/crst_pkg.sv =====
// shared types and constants for the command retransmit slot table
// no dependencies
package crst_pkg;

  localparam int SLOT_COUNT_DEF  = 16;
  localparam int OP_W            = 3;
  localparam int IN_SLOT_W       = 8;
  localparam int TIME_W          = 32;
  localparam int TIMEOUT_W       = 16;
  localparam int STATUS_W        = 3;
  localparam int SLOT_OUT_W      = 5;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

  // request kinds
  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 3'd0,
    OP_FREE    = 3'd1,
    OP_ACK     = 3'd2,
    OP_PROCESS = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_INVALID    = 3'd1,
    STAT_EMPTY      = 3'd2,
    STAT_NOT_SENT   = 3'd3,
    STAT_FULL       = 3'd4
  } status_t;

  // per-slot life cycle
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_READY = 2'd1,
    SLOT_SENT  = 2'd2
  } slot_st_t;

endpackage

// ===== design/crst_time_mem.sv =====
// send timestamp store, one write and one registered read port
// depends on crst_pkg for the timestamp width
module crst_time_mem #(
  parameter int DEPTH = crst_pkg::SLOT_COUNT_DEF,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [crst_pkg::TIME_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [crst_pkg::TIME_W-1:0] rdata
);

  logic [crst_pkg::TIME_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/crst_due_unit.sv =====
// shared due check: wrapping elapsed time against the resend timeout
// depends on crst_pkg for slot states and widths
module crst_due_unit (
  input  crst_pkg::slot_st_t              st,
  input  logic [crst_pkg::TIME_W-1:0]     stamp,
  input  logic [crst_pkg::TIME_W-1:0]     now_ms,
  input  logic [crst_pkg::TIMEOUT_W-1:0]  timeout,
  output logic                            due
);

  logic [crst_pkg::TIME_W-1:0] elapsed;

  // modulo 2^32 elapsed time, then one compare
  assign elapsed = now_ms - stamp;
  assign due = (st == crst_pkg::SLOT_READY) ||
               ((st == crst_pkg::SLOT_SENT) &&
                (elapsed >= crst_pkg::TIME_W'(timeout)));

endmodule

// ===== design/command_retransmit_slot_table.sv =====
// top level of the command retransmit slot table: sequencer, slot states, output register
// depends on crst_pkg, crst_time_mem, crst_due_unit and the assertion macro header
//
// Requests enter on s_tvalid/s_tready: s_tuser carries the request kind, s_tdata the
// slot id and the current time. Results leave on m_tvalid/m_tready with m_tlast on
// the final result of a request. The timeout register is written on cfg_valid and
// is ready outside reset; write it only while the block is idle.
// One request is in flight at a time; s_tready is high only in the idle state.
// Free, ack and query load their result in the lookup state that follows acceptance,
// once the output register is free. Reserve walks the slot states one slot per cycle.
// Process walks every slot through the shared due unit, one slot per cycle while the
// output keeps up, fed by the registered read port of the timestamp store. Each due
// slot is held back until the next due one is found, so the final one can carry m_tlast.
// When the receiver stalls, a finished result waits in the output register while
// the walk carries on; it pauses only when a second result has to be handed over.
// Reset clears every slot to empty, loads the timeout with 1000 ms and drops
// m_tvalid, s_tready and cfg_ready. Timestamps need no reset: read only for sent slots.
`include "command_retransmit_slot_table_macros.svh"
module command_retransmit_slot_table #(
  parameter int SLOT_COUNT = crst_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot [7:0], now_ms [39:8]
  input  logic [2:0]  s_tuser,   // op [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status [2:0], slot_out [7:3], send [8], zero [15:9]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
  localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_RES   = 5'b00100,
    ST_PROC  = 5'b01000,
    ST_FLUSH = 5'b10000
  } seq_t;

  seq_t state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic pend_valid, pend_valid_next;
  logic [IW-1:0] pend_slot, pend_slot_next;

  logic [crst_pkg::OP_W-1:0]      item_op;
  logic [crst_pkg::IN_SLOT_W-1:0] item_slot;
  logic [crst_pkg::TIME_W-1:0]    item_now;
  logic [crst_pkg::TIMEOUT_W-1:0] timeout;

  crst_pkg::slot_st_t slot_state [SLOT_COUNT];
  logic               st_we;
  logic [IW-1:0]      st_waddr;
  crst_pkg::slot_st_t st_wval;
  logic [IW-1:0]      st_raddr;
  crst_pkg::slot_st_t st_rval;

  logic                        mem_we;
  logic [IW-1:0]               mem_raddr;
  logic [crst_pkg::TIME_W-1:0] mem_rdata;
  logic                        due;

  logic                                out_free;
  logic                                out_load;
  logic [crst_pkg::STATUS_W-1:0]       out_status_next;
  logic [crst_pkg::SLOT_OUT_W-1:0]     out_slot_next;
  logic                                out_send_next;
  logic                                out_last_next;
  logic [crst_pkg::STATUS_W-1:0]       out_status;
  logic [crst_pkg::SLOT_OUT_W-1:0]     out_slot;
  logic                                out_send;

  logic s_accept;
  logic look_valid;
  logic advance;
  logic at_last;

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = !rst;
  assign out_free  = !m_tvalid || m_tready;
  assign at_last   = (idx == LAST_IDX);

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= crst_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_accept) begin
      item_op   <= s_tuser;
      item_slot <= s_tdata[7:0];
      item_now  <= s_tdata[39:8];
    end
  end

  // slot state read mux, one address at a time
  assign look_valid = ({1'b0, item_slot} < SLOT_LIMIT);
  assign st_raddr   = (state == ST_LOOK) ? IW'(item_slot) : idx;
  assign st_rval    = slot_state[st_raddr];

  // slot states with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_state[i] <= crst_pkg::SLOT_EMPTY;
      end
    end else if (st_we) begin
      slot_state[st_waddr] <= st_wval;
    end
  end

  // timestamp store and shared due check
  crst_time_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (IW)
  ) u_time_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (item_now),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  crst_due_unit u_due (
    .st      (st_rval),
    .stamp   (mem_rdata),
    .now_ms  (item_now),
    .timeout (timeout),
    .due     (due)
  );

  // walk may step on unless a second due slot meets a busy output
  assign advance = !due || !pend_valid || out_free;

  // read address runs one slot ahead of the walk
  always_comb begin
    mem_raddr = idx;
    if (state == ST_IDLE) begin
      mem_raddr = '0;
    end else if ((state == ST_PROC) && advance && !at_last) begin
      mem_raddr = idx + IW'(1);
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    st_we           = 1'b0;
    st_waddr        = idx;
    st_wval         = crst_pkg::SLOT_EMPTY;
    mem_we          = 1'b0;
    out_load        = 1'b0;
    out_status_next = crst_pkg::STAT_OK;
    out_slot_next   = '0;
    out_send_next   = 1'b0;
    out_last_next   = 1'b1;
    case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (s_accept) begin
          case (s_tuser)
            crst_pkg::OP_RESERVE: state_next = ST_RES;
            crst_pkg::OP_PROCESS: state_next = ST_PROC;
            crst_pkg::OP_FREE,
            crst_pkg::OP_ACK,
            crst_pkg::OP_QUERY:   state_next = ST_LOOK;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOOK: begin
        st_waddr = IW'(item_slot);
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          if (!look_valid) begin
            out_status_next = crst_pkg::STAT_INVALID;
          end else begin
            case (item_op)
              crst_pkg::OP_FREE: begin
                st_we = 1'b1;
              end
              crst_pkg::OP_ACK: begin
                if (st_rval == crst_pkg::SLOT_SENT) begin
                  st_we = 1'b1;
                end else if (st_rval == crst_pkg::SLOT_READY) begin
                  out_status_next = crst_pkg::STAT_NOT_SENT;
                end else begin
                  out_status_next = crst_pkg::STAT_EMPTY;
                end
              end
              crst_pkg::OP_QUERY: begin
                if (st_rval == crst_pkg::SLOT_EMPTY) begin
                  out_status_next = crst_pkg::STAT_EMPTY;
                end
              end
              default: out_status_next = crst_pkg::STAT_OK;
            endcase
          end
        end
      end
      ST_RES: begin
        if (st_rval == crst_pkg::SLOT_EMPTY) begin
          if (out_free) begin
            st_we         = 1'b1;
            st_wval       = crst_pkg::SLOT_READY;
            out_load      = 1'b1;
            out_slot_next = crst_pkg::SLOT_OUT_W'(idx);
            state_next    = ST_IDLE;
          end
        end else if (at_last) begin
          if (out_free) begin
            out_load        = 1'b1;
            out_status_next = crst_pkg::STAT_FULL;
            out_slot_next   = crst_pkg::SLOT_OUT_W'(SLOT_COUNT);
            state_next      = ST_IDLE;
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      ST_PROC: begin
        out_send_next = 1'b1;
        out_last_next = 1'b0;
        out_slot_next = crst_pkg::SLOT_OUT_W'(pend_slot);
        if (advance) begin
          if (due) begin
            st_we           = 1'b1;
            st_wval         = crst_pkg::SLOT_SENT;
            mem_we          = 1'b1;
            out_load        = pend_valid;
            pend_valid_next = 1'b1;
            pend_slot_next  = idx;
          end
          if (at_last) begin
            state_next = (due || pend_valid) ? ST_FLUSH : ST_IDLE;
          end else begin
            idx_next = idx + IW'(1);
          end
        end
      end
      ST_FLUSH: begin
        out_send_next = 1'b1;
        out_slot_next = crst_pkg::SLOT_OUT_W'(pend_slot);
        if (out_free) begin
          out_load        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot <= pend_slot_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= out_status_next;
      out_slot   <= out_slot_next;
      out_send   <= out_send_next;
      m_tlast    <= out_last_next;
    end
  end

  assign m_tdata = {7'b0, out_send, out_slot, out_status};

  // checks
  `CRST_ASSERT_NOW(a_idle_no_pending, clk, rst, s_tready, !pend_valid)
  `CRST_ASSERT_NOW(a_flush_has_pending, clk, rst, state == ST_FLUSH, pend_valid)
  `CRST_ASSERT_NEXT(a_lookup_entry, clk, rst, s_accept && (s_tuser == crst_pkg::OP_FREE || s_tuser == crst_pkg::OP_ACK || s_tuser == crst_pkg::OP_QUERY), state == ST_LOOK)
  `CRST_ASSERT_NOW(a_load_needs_room, clk, rst, out_load, out_free)

endmodule
